@@ src/mwf_pkg.sv @@
// ---------------------------------------------------------------------------
// mwf_pkg
// Types and codes shared by the median window filter and its testbench.
// ---------------------------------------------------------------------------
`default_nettype none

package mwf_pkg;

    localparam int PIX_W = 8;
    localparam int DIM_W = 10;
    localparam int CFG_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W = 21;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSS = 2'd3;

    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] pixel_in;
    } in_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } out_word_t;

endpackage

`default_nettype wire

@@ src/mwf_ram.sv @@
// ---------------------------------------------------------------------------
// mwf_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module mwf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/median_window_filter.sv @@
// ---------------------------------------------------------------------------
// median_window_filter
// Streaming 2-D median over a square or cross window with clamped borders.
//
//   channel  direction  handshake              word
//   in       sink       in_valid / in_stall    in_word  (func, pixel_in)
//   out      source     out_valid / out_stall  out_word (pixel_out, frame_last)
//   cfg      sink       cfg_write              cfg_index, cfg_data
//
// One word per cycle while in_stall is low; the first output of each image row
// first issues one line RAM read per window column (column 0 through
// half_width) and stalls the input. A result passes job, rd, win and c1.
// Reset clears counters and control; line RAM contents are not cleared.
// out_stall while out_valid is high freezes the whole pipeline and stalls the input.
// ---------------------------------------------------------------------------
`default_nettype none

module median_window_filter
    import mwf_pkg::*;
#(
    parameter int MAX_WINDOW = 7,
    parameter int MAX_COLS   = 512
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_word_t              in_word,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_word_t                  out_word,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    localparam int HWM   = (MAX_WINDOW - 1) / 2;
    localparam int WIN   = 2 * HWM + 1;
    localparam int NS    = WIN * WIN;
    localparam int LINES = MAX_WINDOW + 1;
    localparam int CA    = $clog2(MAX_COLS);
    localparam int BW    = $clog2(LINES);
    localparam int RW    = $clog2(NS + 1);
    localparam logic [1:0] HW_CAP = 2'((HWM > 3) ? 3 : HWM);

    // configuration
    logic [DIM_W-1:0] rows_reg, cols_reg;
    logic [1:0]       half_reg;
    logic             cross_reg;

    logic [DIM_W-1:0] rows_eff, cols_eff;
    logic [1:0]       hw_eff;
    logic [CNT_W-1:0] total, lat;

    assign rows_eff = (rows_reg == '0) ? DIM_W'(1) : rows_reg;
    assign cols_eff = (cols_reg == '0) ? DIM_W'(1) :
                      (32'(cols_reg) > MAX_COLS) ? DIM_W'(MAX_COLS) : cols_reg;
    assign hw_eff   = (half_reg > HW_CAP) ? HW_CAP : half_reg;
    assign total    = CNT_W'(rows_eff) * CNT_W'(cols_eff);
    assign lat      = CNT_W'(hw_eff) * CNT_W'(cols_eff) + CNT_W'(hw_eff);

    // stream position counters
    logic [CNT_W-1:0] in_cnt_reg, in_cnt_next, out_cnt_reg, out_cnt_next;
    logic [DIM_W-1:0] in_row_reg, in_row_next, in_col_reg, in_col_next;
    logic [DIM_W-1:0] out_row_reg, out_row_next, out_col_reg, out_col_next;
    logic [BW-1:0]    in_bank_reg, in_bank_next, out_bank_reg, out_bank_next;

    // job sequencer
    logic             job_busy_reg, job_busy_next;
    logic [DIM_W-1:0] job_row_reg, job_row_next, job_col_reg, job_col_next;
    logic [BW-1:0]    job_bank_reg, job_bank_next;
    logic             job_last_reg, job_last_next;
    logic [1:0]       job_step_reg, job_step_next;
    logic             job_prime_reg, job_prime_next;

    // pipeline
    logic             rd_v_reg, rd_fill_reg, rd_final_reg, rd_last_reg;
    logic [DIM_W-1:0] rd_row_reg;
    logic [BW-1:0]    rd_bank_reg;
    logic             w_v_reg, w_last_reg;
    logic [PIX_W-1:0] win_reg [NS];
    logic [PIX_W-1:0] win_next [NS];
    logic             c1_v_reg, c1_last_reg;
    logic [PIX_W-1:0] c1_samp_reg [NS];
    logic [NS-1:0]    c1_bef_reg [NS];
    logic [NS-1:0]    c1_bef_next [NS];
    logic             out_valid_reg;
    out_word_t        out_word_reg, out_word_next;

    logic             go, in_acc, take_px, emit, frame_end, col_wrap, in_wrap;
    logic             issue, issue_final, free;
    logic [CNT_W-1:0] rcv_next;
    logic [DIM_W:0]   col_want;
    logic [DIM_W-1:0] rd_col;
    logic [PIX_W-1:0] bank_q [LINES];
    logic [PIX_W-1:0] colv [WIN];
    logic signed [DIM_W+1:0] row_try [WIN];
    logic signed [BW+1:0]    off_s [WIN];
    logic signed [BW+1:0]    bank_s [WIN];
    logic [NS-1:0]    mask;
    logic [RW-1:0]    target;
    logic [2:0]       side;
    logic [5:0]       sq;

    assign go        = !out_valid_reg || !out_stall;
    assign issue     = go && job_busy_reg;
    assign issue_final = issue && (!job_prime_reg || job_step_reg == hw_eff);
    assign free      = !job_busy_reg || issue_final;
    assign in_stall  = !(go && free);
    assign in_acc    = in_valid && !in_stall;

    assign take_px   = (in_word.func == FUNC_PIXEL) && (in_cnt_reg < total);
    assign rcv_next  = in_cnt_reg + CNT_W'(take_px);
    assign emit      = in_acc && (out_cnt_reg < total) &&
                       (rcv_next >= total || rcv_next >= out_cnt_reg + lat + CNT_W'(1));
    assign col_wrap  = out_col_reg == cols_eff - DIM_W'(1);
    assign frame_end = emit && col_wrap && (out_row_reg == rows_eff - DIM_W'(1));
    assign in_wrap   = in_col_reg == cols_eff - DIM_W'(1);

    always_comb
    begin
        in_cnt_next   = in_cnt_reg;
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_bank_next  = in_bank_reg;
        out_cnt_next  = out_cnt_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_bank_next = out_bank_reg;
        if (cfg_write || frame_end)
        begin
            in_cnt_next   = '0;
            in_row_next   = '0;
            in_col_next   = '0;
            in_bank_next  = '0;
            out_cnt_next  = '0;
            out_row_next  = '0;
            out_col_next  = '0;
            out_bank_next = '0;
        end
        else if (in_acc)
        begin
            if (take_px)
            begin
                in_cnt_next = rcv_next;
                if (in_wrap)
                begin
                    in_col_next  = '0;
                    in_row_next  = in_row_reg + DIM_W'(1);
                    in_bank_next = (in_bank_reg == BW'(LINES - 1)) ? '0
                                                                   : in_bank_reg + BW'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + DIM_W'(1);
                end
            end
            if (emit)
            begin
                out_cnt_next = out_cnt_reg + CNT_W'(1);
                if (col_wrap)
                begin
                    out_col_next  = '0;
                    out_row_next  = out_row_reg + DIM_W'(1);
                    out_bank_next = (out_bank_reg == BW'(LINES - 1)) ? '0
                                                                     : out_bank_reg + BW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + DIM_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        job_busy_next  = job_busy_reg;
        job_row_next   = job_row_reg;
        job_col_next   = job_col_reg;
        job_bank_next  = job_bank_reg;
        job_last_next  = job_last_reg;
        job_step_next  = job_step_reg;
        job_prime_next = job_prime_reg;
        if (emit)
        begin
            job_busy_next  = 1'b1;
            job_row_next   = out_row_reg;
            job_col_next   = out_col_reg;
            job_bank_next  = out_bank_reg;
            job_last_next  = frame_end;
            job_step_next  = '0;
            job_prime_next = (out_col_reg == '0);
        end
        else if (issue_final)
        begin
            job_busy_next = 1'b0;
        end
        else if (issue)
        begin
            job_step_next = job_step_reg + 2'd1;
        end
    end

    // column address for this read, clamped at the right edge
    assign col_want = job_prime_reg ? (DIM_W + 1)'(job_step_reg)
                                    : {1'b0, job_col_reg} + (DIM_W + 1)'(hw_eff);
    assign rd_col   = (col_want > {1'b0, cols_eff - DIM_W'(1)}) ? cols_eff - DIM_W'(1)
                                                                 : col_want[DIM_W-1:0];

    for (genvar b = 0; b < LINES; b++)
    begin : g_bank
        mwf_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_COLS)
        ) u_line (
            .clk   (clk),
            .we    (in_acc && take_px && in_bank_reg == BW'(b)),
            .waddr (CA'(in_col_reg)),
            .wdata (in_word.pixel_in),
            .re    (issue),
            .raddr (CA'(rd_col)),
            .rdata (bank_q[b])
        );
    end

    // gather one window column, rows clamped to the image
    always_comb
    begin
        for (int s = 0; s < WIN; s++)
        begin
            row_try[s] = signed'({2'b00, rd_row_reg}) + (DIM_W + 2)'(s - HWM);
            if (row_try[s] < 0)
            begin
                off_s[s] = -(BW + 2)'(signed'({2'b00, rd_row_reg}));
            end
            else if (row_try[s] > signed'({2'b00, rows_eff - DIM_W'(1)}))
            begin
                off_s[s] = (BW + 2)'(signed'({2'b00, rows_eff - DIM_W'(1) - rd_row_reg}));
            end
            else
            begin
                off_s[s] = (BW + 2)'(s - HWM);
            end
            bank_s[s] = signed'({2'b00, rd_bank_reg}) + off_s[s];
            if (bank_s[s] < 0)
            begin
                bank_s[s] = bank_s[s] + (BW + 2)'(LINES);
            end
            else if (bank_s[s] >= (BW + 2)'(LINES))
            begin
                bank_s[s] = bank_s[s] - (BW + 2)'(LINES);
            end
            colv[s] = bank_q[bank_s[s][BW-1:0]];
        end
    end

    always_comb
    begin
        for (int c = 0; c < WIN; c++)
        begin
            for (int r = 0; r < WIN; r++)
            begin
                if (rd_fill_reg || c == HWM + int'(hw_eff))
                begin
                    win_next[c*WIN+r] = colv[r];
                end
                else if (c < WIN - 1)
                begin
                    win_next[c*WIN+r] = win_reg[(c+1)*WIN+r];
                end
                else
                begin
                    win_next[c*WIN+r] = win_reg[c*WIN+r];
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            for (int j = 0; j < NS; j++)
            begin
                c1_bef_next[i][j] = (win_reg[j] < win_reg[i]) ||
                                    (win_reg[j] == win_reg[i] && j < i);
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < WIN; c++)
        begin
            for (int r = 0; r < WIN; r++)
            begin
                mask[c*WIN+r] = (c >= HWM - int'(hw_eff)) && (c <= HWM + int'(hw_eff)) &&
                                (r >= HWM - int'(hw_eff)) && (r <= HWM + int'(hw_eff)) &&
                                (!cross_reg || c == HWM || r == HWM);
            end
        end
    end

    assign side   = {hw_eff, 1'b1};
    assign sq     = 6'(side) * 6'(side);
    assign target = cross_reg ? RW'({hw_eff, 1'b0}) : RW'(sq >> 1);

    always_comb
    begin
        out_word_next.pixel_out  = '0;
        out_word_next.frame_last = c1_last_reg;
        for (int i = 0; i < NS; i++)
        begin
            if (mask[i] && RW'($countones(c1_bef_reg[i] & mask)) == target)
            begin
                out_word_next.pixel_out = out_word_next.pixel_out | c1_samp_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= DIM_W'(256);
            cols_reg      <= DIM_W'(256);
            half_reg      <= 2'd3;
            cross_reg     <= 1'b0;
            in_cnt_reg    <= '0;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            in_bank_reg   <= '0;
            out_cnt_reg   <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_bank_reg  <= '0;
            job_busy_reg  <= 1'b0;
            job_step_reg  <= '0;
            job_prime_reg <= 1'b0;
            rd_v_reg      <= 1'b0;
            rd_final_reg  <= 1'b0;
            w_v_reg       <= 1'b0;
            c1_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ROWS:  rows_reg  <= cfg_data;
                    CFG_COLS:  cols_reg  <= cfg_data;
                    CFG_HALF:  half_reg  <= cfg_data[1:0];
                    CFG_CROSS: cross_reg <= cfg_data[0];
                    default:   ;
                endcase
            end
            in_cnt_reg    <= in_cnt_next;
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            in_bank_reg   <= in_bank_next;
            out_cnt_reg   <= out_cnt_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            out_bank_reg  <= out_bank_next;
            job_busy_reg  <= job_busy_next;
            job_step_reg  <= job_step_next;
            job_prime_reg <= job_prime_next;
            if (go)
            begin
                rd_v_reg      <= issue;
                rd_final_reg  <= issue_final;
                w_v_reg       <= rd_v_reg && rd_final_reg;
                c1_v_reg      <= w_v_reg;
                out_valid_reg <= c1_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_row_reg  <= job_row_next;
        job_col_reg  <= job_col_next;
        job_bank_reg <= job_bank_next;
        job_last_reg <= job_last_next;
        if (go)
        begin
            rd_fill_reg <= job_prime_reg && job_step_reg == '0;
            rd_row_reg  <= job_row_reg;
            rd_bank_reg <= job_bank_reg;
            rd_last_reg <= job_last_reg;
            if (rd_v_reg)
            begin
                win_reg    <= win_next;
                w_last_reg <= rd_last_reg;
            end
            c1_samp_reg  <= win_reg;
            c1_bef_reg   <= c1_bef_next;
            c1_last_reg  <= w_last_reg;
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_out_behind_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg <= in_cnt_reg)
        else $error("output position ahead of input position");

    a_in_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_write |-> in_cnt_reg <= total)
        else $error("input position beyond frame");

    a_prime_bound: assert property (@(posedge clk) disable iff (!rst_n)
        job_busy_reg && job_prime_reg |-> job_step_reg <= hw_eff)
        else $error("priming read past window edge");

    a_job_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !job_busy_reg || issue_final)
        else $error("new job while sequencer busy");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for median_window_filter.
// Streams image planes under a series of window and size settings, and
// predicts every median and frame-end flag in a scoreboard. Both sides of
// the stream idle and stall at random, each side alone and then both together.
// ---------------------------------------------------------------------------
module testbench;
    import mwf_pkg::*;

    localparam int LINE_COUNT = 8;
    localparam int COL_LIMIT = 512;
    localparam int HW_LIMIT = 3;
    localparam int CYCLE_LIMIT = 1000000;

    class median_scoreboard;
        logic [PIX_W-1:0] line_store [LINE_COUNT*COL_LIMIT];
        int in_row, in_col, out_row, out_col;
        int rows_reg, cols_reg, hw_reg, cross_reg;
        out_word_t medians_due[$];
        int errors;
        bit frame_done;

        function new();
            foreach (line_store[i]) line_store[i] = '0;
            rows_reg = 256;
            cols_reg = 256;
            hw_reg = 3;
            cross_reg = 0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            in_row = 0;
            in_col = 0;
            out_row = 0;
            out_col = 0;
        endfunction

        function int rows();
            return rows_reg == 0 ? 1 : rows_reg;
        endfunction

        function int cols();
            if (cols_reg == 0) return 1;
            return cols_reg > COL_LIMIT ? COL_LIMIT : cols_reg;
        endfunction

        function int hw();
            return hw_reg > HW_LIMIT ? HW_LIMIT : hw_reg;
        endfunction

        function bit fully_in();
            return in_row >= rows();
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_ROWS: rows_reg = data;
                CFG_COLS: cols_reg = data;
                CFG_HALF: hw_reg = data[1:0];
                CFG_CROSS: cross_reg = data[0];
                default: ;
            endcase
            restart();
        endfunction

        function logic [PIX_W-1:0] fetch(int r, int c);
            if (r < 0) r = 0;
            if (r > rows() - 1) r = rows() - 1;
            if (c < 0) c = 0;
            if (c > cols() - 1) c = cols() - 1;
            return line_store[(r % LINE_COUNT) * COL_LIMIT + c];
        endfunction

        function void note_pixel_word(in_word_t w);
            int nr, nc, h, total, received, oi;
            int samples[$];
            out_word_t o;
            nr = rows();
            nc = cols();
            h = hw();
            total = nr * nc;
            if (w.func == FUNC_PIXEL && in_row < nr) begin
                line_store[(in_row % LINE_COUNT) * COL_LIMIT + in_col] = w.pixel_in;
                in_col++;
                if (in_col >= nc) begin
                    in_col = 0;
                    in_row++;
                end
            end
            received = in_row >= nr ? total : in_row * nc + in_col;
            oi = out_row * nc + out_col;
            if (oi >= total) return;
            if (!(received >= total || received >= oi + h * nc + h + 1)) return;
            for (int di = -h; di <= h; di++)
                for (int dj = -h; dj <= h; dj++)
                    if (cross_reg == 0 || di == 0 || dj == 0)
                        samples.push_back(fetch(out_row + di, out_col + dj));
            samples.sort();
            o.pixel_out = samples[samples.size() / 2];
            o.frame_last = 1'b0;
            out_col++;
            if (out_col >= nc) begin
                out_col = 0;
                out_row++;
            end
            if (out_row >= nr) begin
                o.frame_last = 1'b1;
                frame_done = 1'b1;
                restart();
            end
            medians_due.push_back(o);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_word(out_word_t got);
            out_word_t want;
            if (medians_due.size() == 0) begin
                report($sformatf("unexpected word pixel_out=%0d frame_last=%0d",
                                 got.pixel_out, got.frame_last));
                return;
            end
            want = medians_due.pop_front();
            if (got.pixel_out !== want.pixel_out)
                report($sformatf("pixel_out got %0d want %0d", got.pixel_out, want.pixel_out));
            if (got.frame_last !== want.frame_last)
                report($sformatf("frame_last got %0d want %0d",
                                 got.frame_last, want.frame_last));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_word_t in_word;
    logic out_valid;
    logic out_stall;
    out_word_t out_word;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    median_scoreboard sb;
    int idle_mode;
    int cycles;
    int pixels_sent;

    median_window_filter i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_word(in_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word(out_word),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(negedge clk)
    begin
        if (idle_mode == 2)
            out_stall <= $urandom_range(99) < 80;
        else if (idle_mode == 3)
            out_stall <= $urandom_range(99) < 22;
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && out_valid && !out_stall)
            sb.check_word(out_word);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task send(logic func, logic [PIX_W-1:0] pix);
        in_word_t w;
        w.func = func;
        w.pixel_in = pix;
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (in_stall);
        sb.note_pixel_word(w);
        if (func == FUNC_PIXEL) pixels_sent++;
        @(negedge clk);
        if ((idle_mode == 1 && $urandom_range(99) < 80) ||
            (idle_mode == 3 && $urandom_range(99) < 22))
        begin
            in_valid <= 1'b0;
            in_word <= in_word_t'({1'($urandom), PIX_W'($urandom)});
            @(negedge clk);
            while ((idle_mode == 1 && $urandom_range(99) < 80) ||
                   (idle_mode == 3 && $urandom_range(99) < 22))
                @(negedge clk);
        end
    endtask

    task hold_idle();
        in_valid <= 1'b0;
        while (sb.medians_due.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.configure(idx, data);
    endtask

    task setup(int r, int c, int h, int x);
        hold_idle();
        write_reg(CFG_ROWS, CFG_W'(r));
        write_reg(CFG_COLS, CFG_W'(c));
        write_reg(CFG_HALF, CFG_W'(h));
        write_reg(CFG_CROSS, CFG_W'(x));
    endtask

    function logic [PIX_W-1:0] pick_pixel(int style);
        case (style)
            0: return PIX_W'($urandom_range(255));
            1: return $urandom_range(1) ? 8'hFF : 8'h00;
            default: return PIX_W'(100 + $urandom_range(12));
        endcase
    endfunction

    // partial > 0 sends only that many pixels and abandons the frame
    task run_frame(int partial, bit pause_mid);
        int npix, style;
        npix = partial > 0 ? partial : sb.rows() * sb.cols();
        style = $urandom_range(2);
        sb.frame_done = 1'b0;
        for (int k = 0; k < npix; k++)
        begin
            if ($urandom_range(99) < 5) send(FUNC_DRAIN, PIX_W'($urandom));
            if (pause_mid && k == npix / 2) hold_idle();
            send(FUNC_PIXEL, pick_pixel(style));
        end
        if (partial > 0) return;
        while (!sb.frame_done)
        begin
            if ($urandom_range(99) < 10)
                send(FUNC_PIXEL, PIX_W'($urandom));
            else
                send(FUNC_DRAIN, PIX_W'($urandom));
        end
    endtask

    int plan [12][5] = '{
        '{3, 3, 1, 0, 0}, '{1, 1, 0, 0, 0}, '{0, 0, 3, 1, 0}, '{4, 5, 2, 1, 0},
        '{5, 4, 3, 0, 0}, '{8, 6, 3, 1, 0}, '{1, 1023, 1, 0, 40}, '{1023, 1, 3, 0, 30},
        '{2, 512, 3, 1, 100}, '{7, 9, 2, 0, 0}, '{6, 7, 1, 1, 0}, '{9, 12, 0, 1, 0}
    };

    initial
    begin
        sb = new();
        idle_mode = 0;
        pixels_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: fixed shapes, extremes of every register
        for (int p = 0; p < 12; p++)
        begin
            setup(plan[p][0], plan[p][1], plan[p][2], plan[p][3]);
            if (p == 8) idle_mode = 0;
            run_frame(plan[p][4], p == 4);
        end

        // random frames, cycling through the idling modes
        for (int p = 0; pixels_sent < 650; p++)
        begin
            idle_mode = p % 4;
            setup($urandom_range(10, 1), $urandom_range(12, 1),
                  $urandom_range(3), $urandom_range(1));
            run_frame(0, p == 1);
        end

        in_valid <= 1'b0;
        while (sb.medians_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
